// ===== rtl/fbr_pkg.sv =====
// Package with the shared types and constants of the BLE fragment reassembler.
`timescale 1ns / 1ps

package fbr_pkg;

    localparam int BUF_DEPTH = 1024;
    localparam int ADDR_W = $clog2(BUF_DEPTH);
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);
    localparam int SEQ_W = 7;
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] INIT_MARK = 8'h80;
    localparam logic [7:0] SEQ_MASK = 8'h7f;

    localparam logic OP_FRAG = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_HEADER,
        MODE_PAYLOAD
    } mode_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] frag_byte;
        logic       frag_first;
        logic       frag_last;
        logic [9:0] read_index;
    } req_t;

    typedef struct packed {
        logic        complete;
        logic [10:0] message_length;
        logic [7:0]  read_byte;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic        is_read;
        logic        in_range;
        logic        complete;
        logic [10:0] message_length;
    } res_info_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

// ===== rtl/fbr_ctrl.sv =====
// Reassembly control: header decode, sequence check, counters and store requests.
`timescale 1ns / 1ps

module fbr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  fbr_pkg::req_t       req,
    output fbr_pkg::mem_req_t   mem_req,
    output fbr_pkg::res_info_t  info
);

    fbr_pkg::mode_t                    mode_reg, mode_next;
    logic [1:0]                        pos_reg, pos_next;
    logic [fbr_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [fbr_pkg::CNT_W-1:0]         total_reg, total_next;
    logic [fbr_pkg::SEQ_W-1:0]         seq_reg, seq_next;
    logic [7:0]                        high_reg, high_next;
    logic                              store_en;
    logic                              done;
    logic [fbr_pkg::CNT_W-1:0]         done_len;
    logic [15:0]                       hdr_total;

    assign hdr_total = {high_reg, req.frag_byte};

    always_comb
    begin
        mode_next = mode_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        total_next = total_reg;
        seq_next = seq_reg;
        high_next = high_reg;
        store_en = 1'b0;
        done = 1'b0;
        done_len = '0;
        if (accept && req.opcode == fbr_pkg::OP_FRAG)
        begin
            if (req.frag_first)
            begin
                pos_next = 2'd0;
                if ((req.frag_byte & fbr_pkg::INIT_MARK) != 8'h00)
                begin
                    mode_next = fbr_pkg::MODE_HEADER;
                    pos_next = 2'd1;
                end
                else if (total_reg == '0 ||
                         (req.frag_byte & fbr_pkg::SEQ_MASK) != {1'b0, seq_reg})
                begin
                    mode_next = fbr_pkg::MODE_IDLE;
                end
                else
                begin
                    seq_next = seq_reg + 1'b1;
                    mode_next = fbr_pkg::MODE_PAYLOAD;
                end
            end
            else if (mode_reg == fbr_pkg::MODE_HEADER)
            begin
                if (pos_reg == 2'd1)
                begin
                    high_next = req.frag_byte;
                    pos_next = 2'd2;
                end
                else
                begin
                    pos_next = 2'd0;
                    if (hdr_total > 16'(fbr_pkg::BUF_DEPTH))
                    begin
                        total_next = '0;
                        mode_next = fbr_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        total_next = hdr_total[fbr_pkg::CNT_W-1:0];
                        cnt_next = '0;
                        seq_next = '0;
                        mode_next = fbr_pkg::MODE_PAYLOAD;
                    end
                end
            end
            else if (mode_reg == fbr_pkg::MODE_PAYLOAD)
            begin
                if (cnt_reg < total_reg &&
                    cnt_reg < fbr_pkg::CNT_W'(fbr_pkg::BUF_DEPTH))
                begin
                    store_en = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            if (req.frag_last)
            begin
                if (mode_next == fbr_pkg::MODE_PAYLOAD && total_next != '0 &&
                    cnt_next >= total_next)
                begin
                    done = 1'b1;
                    done_len = total_next;
                    total_next = '0;
                    cnt_next = '0;
                end
                mode_next = fbr_pkg::MODE_IDLE;
                pos_next = 2'd0;
            end
        end
    end

    always_comb
    begin
        mem_req.wr_en = store_en;
        mem_req.rd_en = accept && req.opcode == fbr_pkg::OP_READ;
        mem_req.addr = store_en ? cnt_reg[fbr_pkg::ADDR_W-1:0]
                                : req.read_index[fbr_pkg::ADDR_W-1:0];
        mem_req.wdata = req.frag_byte;
        info.valid = accept;
        info.is_read = req.opcode == fbr_pkg::OP_READ;
        info.in_range = {1'b0, req.read_index} < 11'(fbr_pkg::BUF_DEPTH);
        info.complete = done;
        info.message_length = 11'(done_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fbr_pkg::MODE_IDLE;
            pos_reg <= 2'd0;
            cnt_reg <= '0;
            total_reg <= '0;
            seq_reg <= '0;
            high_reg <= 8'h00;
        end
        else
        begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            total_reg <= total_next;
            seq_reg <= seq_next;
            high_reg <= high_next;
        end
    end

endmodule

// ===== rtl/fbr_mem.sv =====
// Message store: single-port synchronous memory with a registered read word.
`timescale 1ns / 1ps

module fbr_mem (
    input  logic              clk,
    input  fbr_pkg::mem_req_t mem_req,
    output logic [7:0]        rdata
);

    logic [7:0] mem [fbr_pkg::BUF_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.addr] <= mem_req.wdata;
        end
        if (mem_req.rd_en)
        begin
            rdata_reg <= mem[mem_req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fbr_outq.sv =====
// Result stage and output queue that absorbs output stalls.
`timescale 1ns / 1ps

module fbr_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  fbr_pkg::res_info_t info,
    input  logic [7:0]         rdata,
    output logic               full,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output fbr_pkg::rsp_t      rsp
);

    fbr_pkg::res_info_t           s1_reg;
    fbr_pkg::rsp_t                q_reg [fbr_pkg::OQ_DEPTH];
    logic [fbr_pkg::OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fbr_pkg::OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fbr_pkg::OQ_CNT_W-1:0] count_reg, count_next;
    logic                         push;
    logic                         pop;
    fbr_pkg::rsp_t                push_word;

    assign push = s1_reg.valid;
    assign pop = rsp_valid && !rsp_stall;

    always_comb
    begin
        push_word.complete = s1_reg.complete;
        push_word.message_length = s1_reg.message_length;
        push_word.read_byte = (s1_reg.is_read && s1_reg.in_range) ? rdata : 8'h00;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == fbr_pkg::OQ_PTR_W'(fbr_pkg::OQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == fbr_pkg::OQ_PTR_W'(fbr_pkg::OQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + fbr_pkg::OQ_CNT_W'(push) - fbr_pkg::OQ_CNT_W'(pop);
    end

    assign rsp_valid = count_reg != '0;
    assign rsp = q_reg[rd_ptr_reg];
    assign full = ({1'b0, count_reg} + {{fbr_pkg::OQ_CNT_W{1'b0}}, s1_reg.valid})
                  >= (fbr_pkg::OQ_CNT_W + 1)'(fbr_pkg::OQ_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            s1_reg <= info;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/fido_ble_fragment_reassembler_top.sv =====
// Each accepted word passes the result stage register, beside the store's registered read word, then the output queue.
// One word is accepted per cycle while req_stall is low; the store takes at most one access per word.
// Input stall rises when the output queue and the result stage together hold three words.
// Reset clears the reassembly state and the queue at once; no clearing pass.
// Message store contents are undefined after reset until written.
`timescale 1ns / 1ps

module fido_ble_fragment_reassembler_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  fbr_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output fbr_pkg::rsp_t  rsp
);

    logic               accept;
    logic               full;
    logic [7:0]         rdata;
    fbr_pkg::mem_req_t  mem_req;
    fbr_pkg::res_info_t info;

    assign req_stall = full;
    assign accept = req_valid && !full;

    fbr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (req),
        .mem_req (mem_req),
        .info    (info)
    );

    fbr_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    fbr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .info      (info),
        .rdata     (rdata),
        .full      (full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
